// ===== rtl/core/ppb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppb_pkg: shared constants for the pressure plate balance block
// field widths, default parameter values, op codes and queue depths
// ----------------------------------------------------------------------------
package ppb_pkg;

    // fixed field widths
    localparam int PLATE_W  = 3;
    localparam int DIFF_W   = 14;
    localparam int CH_COUNT = 4;

    // parameter defaults
    localparam int DEF_PLATE_COUNT = 8;
    localparam int DEF_CAL_READS   = 16;
    localparam int DEF_AVG_READS   = 4;
    localparam int DEF_SAMPLE_BITS = 12;

    // op codes
    localparam logic OP_CAL  = 1'b0;
    localparam logic OP_MEAS = 1'b1;

    // front queue, power of two
    localparam int FRONT_DEPTH = 4;
    localparam int FQ_AW       = $clog2(FRONT_DEPTH);
    localparam int FQ_CNT_W    = $clog2(FRONT_DEPTH + 1);

    // result queue, power of two
    localparam int OUT_DEPTH = 8;
    localparam int OQ_AW     = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

endpackage
`default_nettype wire

// ===== rtl/core/ppb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppb_ram: generic simple dual port ram
// one write port, one read port with registered read data (read old on clash)
// ----------------------------------------------------------------------------
module ppb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ppb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppb_front: input side of the balance block
// accepts words, drops plates out of range, queues the rest for the back end
// ----------------------------------------------------------------------------
module ppb_front #(
    parameter int PLATE_COUNT = ppb_pkg::DEF_PLATE_COUNT,
    parameter int SAMPLE_BITS = ppb_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     push,
    output logic                                     full,
    input  logic                                     op,
    input  logic [ppb_pkg::PLATE_W-1:0]              plate,
    input  logic [SAMPLE_BITS-1:0]                   ch0,
    input  logic [SAMPLE_BITS-1:0]                   ch1,
    input  logic [SAMPLE_BITS-1:0]                   ch2,
    input  logic [SAMPLE_BITS-1:0]                   ch3,
    output logic                                     q_valid,
    input  logic                                     q_pop,
    output logic                                     q_op,
    output logic [ppb_pkg::PLATE_W-1:0]              q_plate,
    output logic [ppb_pkg::CH_COUNT-1:0][SAMPLE_BITS-1:0] q_samples
);

    import ppb_pkg::*;

    typedef struct packed {
        logic                                 op;
        logic [PLATE_W-1:0]                   plate;
        logic [CH_COUNT-1:0][SAMPLE_BITS-1:0] samples;
    } fq_entry_t;

    fq_entry_t           entry_reg [FRONT_DEPTH];
    fq_entry_t           wr_entry;
    logic [FQ_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [FQ_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                in_range;
    logic                do_wr;
    logic                do_rd;

    // plates past the configured count are taken and thrown away
    assign in_range = (32'(plate) < 32'(PLATE_COUNT));
    assign full     = (cnt_reg == FQ_CNT_W'(FRONT_DEPTH));
    assign do_wr    = push && !full && in_range;
    assign q_valid  = (cnt_reg != '0);
    assign do_rd    = q_pop && q_valid;

    assign wr_entry.op      = op;
    assign wr_entry.plate   = plate;
    assign wr_entry.samples = {ch3, ch2, ch1, ch0};

    assign q_op      = entry_reg[rd_ptr_reg].op;
    assign q_plate   = entry_reg[rd_ptr_reg].plate;
    assign q_samples = entry_reg[rd_ptr_reg].samples;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FQ_AW'(do_wr);
        rd_ptr_next = rd_ptr_reg + FQ_AW'(do_rd);
        cnt_next    = cnt_reg + FQ_CNT_W'(do_wr) - FQ_CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ppb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppb_back: accumulate, divide and balance pipeline
// s1 read-modify-write of the per-plate sums, s2 reciprocal multiply,
// s3 quotient and baseline update, s4 pair means and differences
// ----------------------------------------------------------------------------
module ppb_back #(
    parameter int PLATE_COUNT = ppb_pkg::DEF_PLATE_COUNT,
    parameter int CAL_READS   = ppb_pkg::DEF_CAL_READS,
    parameter int AVG_READS   = ppb_pkg::DEF_AVG_READS,
    parameter int SAMPLE_BITS = ppb_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_pop,
    input  logic                                          in_op,
    input  logic [ppb_pkg::PLATE_W-1:0]                   in_plate,
    input  logic [ppb_pkg::CH_COUNT-1:0][SAMPLE_BITS-1:0] in_samples,
    input  logic [ppb_pkg::OCNT_W-1:0]                    out_count,
    output logic                                          res_push,
    output logic [ppb_pkg::PLATE_W-1:0]                   res_plate,
    output logic [ppb_pkg::DIFF_W-1:0]                    res_dx,
    output logic [ppb_pkg::DIFF_W-1:0]                    res_dy
);

    import ppb_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int ADDR_W = (PLATE_COUNT > 1) ? $clog2(PLATE_COUNT) : 1;
    localparam int CAL_L  = $clog2(CAL_READS);
    localparam int AVG_L  = $clog2(AVG_READS);
    localparam int CSW    = SB + CAL_L;
    localparam int ASW    = SB + AVG_L;
    localparam int CCW    = (CAL_L > 0) ? CAL_L : 1;
    localparam int ACW    = (AVG_L > 0) ? AVG_L : 1;
    localparam int DIV_W  = (CSW > ASW) ? CSW : ASW;
    localparam int MW     = DIV_W + 2;
    localparam int PRW    = DIV_W + MW;
    localparam int CAL_SH = DIV_W + CAL_L;
    localparam int AVG_SH = DIV_W + AVG_L;
    localparam int XW     = ((SB + 3) > DIFF_W) ? (SB + 3) : DIFF_W;
    localparam int OCC_W  = OCNT_W + 1;

    // round-up reciprocals, exact for any dividend below 2**DIV_W
    localparam logic [63:0] CAL_M64 = ((64'd1 << CAL_SH) / CAL_READS) + 64'd1;
    localparam logic [63:0] AVG_M64 = ((64'd1 << AVG_SH) / AVG_READS) + 64'd1;
    localparam logic [MW-1:0] CAL_M = CAL_M64[MW-1:0];
    localparam logic [MW-1:0] AVG_M = AVG_M64[MW-1:0];

    typedef struct packed {
        logic [CCW-1:0]                cal_cnt;
        logic [CH_COUNT-1:0][CSW-1:0]  cal_sum;
        logic [ACW-1:0]                avg_cnt;
        logic [CH_COUNT-1:0][ASW-1:0]  avg_sum;
    } acc_row_t;

    localparam int ROW_W = $bits(acc_row_t);
    localparam int BL_W  = CH_COUNT * SB;

    // ---------------- s1: accumulator read-modify-write ----------------
    logic                              s1_valid_reg;
    logic                              s1_op_reg;
    logic [PLATE_W-1:0]                s1_plate_reg;
    logic [CH_COUNT-1:0][SB-1:0]       s1_samples_reg;
    logic [PLATE_COUNT-1:0]            acc_vld_reg;
    logic                              acc_vld_rd_reg;
    logic                              fwd_reg;
    acc_row_t                          fwd_row_reg;
    logic [ROW_W-1:0]                  acc_rdata;
    acc_row_t                          acc_rd;
    acc_row_t                          acc_cur;
    acc_row_t                          acc_new;
    logic [CH_COUNT-1:0][CSW-1:0]      cal_add;
    logic [CH_COUNT-1:0][ASW-1:0]      avg_add;
    logic [CCW:0]                      cal_cnt1;
    logic [ACW:0]                      avg_cnt1;
    logic                              cal_done;
    logic                              avg_done;
    logic                              s1_done;
    logic [CH_COUNT-1:0][DIV_W-1:0]    div_src;
    logic [OCC_W-1:0]                  occupancy;
    logic                              pop_ok;
    logic                              fwd_next;

    // ---------------- s2: multiply ----------------
    logic                              s2_valid_reg;
    logic                              s2_op_reg;
    logic                              s2_done_reg;
    logic [PLATE_W-1:0]                s2_plate_reg;
    logic [CH_COUNT-1:0][DIV_W-1:0]    s2_src_reg;
    logic [MW-1:0]                     m_sel;
    logic [PLATE_COUNT-1:0]            bl_vld_reg;
    logic                              bl_vld_rd_reg;

    // ---------------- s3: quotient, baseline ----------------
    logic                              s3_valid_reg;
    logic                              s3_op_reg;
    logic                              s3_done_reg;
    logic [PLATE_W-1:0]                s3_plate_reg;
    logic [CH_COUNT-1:0][PRW-1:0]      s3_prod_reg;
    logic [CH_COUNT-1:0][SB-1:0]       quot;
    logic [BL_W-1:0]                   bl_rdata;
    logic [CH_COUNT-1:0][SB-1:0]       base;
    logic                              bl_we;
    logic                              bfwd_reg;
    logic [CH_COUNT-1:0][SB-1:0]       bfwd_data_reg;
    logic                              bfwd_next;
    logic [CH_COUNT-1:0][SB:0]         corr;

    // ---------------- s4: balance ----------------
    logic                              s4_valid_reg;
    logic [PLATE_W-1:0]                s4_plate_reg;
    logic [CH_COUNT-1:0][SB:0]         s4_c_reg;
    logic signed [XW-1:0]              p01, p13, p23, p02;
    logic signed [XW-1:0]              m01, m13, m23, m02;
    logic signed [XW-1:0]              dx, dy;

    function automatic logic signed [XW-1:0] half_tz(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = v + $signed({{(XW-1){1'b0}}, v[XW-1]});
        return t >>> 1;
    endfunction

    // pop only when the result queue has room for everything in flight
    assign occupancy = OCC_W'(out_count) + OCC_W'(s1_valid_reg) + OCC_W'(s2_valid_reg)
                     + OCC_W'(s3_valid_reg) + OCC_W'(s4_valid_reg);
    assign pop_ok    = in_valid && (occupancy < OCC_W'(OUT_DEPTH));
    assign in_pop    = pop_ok;

    ppb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (PLATE_COUNT)
    ) u_acc_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (ADDR_W'(s1_plate_reg)),
        .wdata (acc_new),
        .re    (pop_ok),
        .raddr (ADDR_W'(in_plate)),
        .rdata (acc_rdata)
    );

    assign acc_rd = acc_row_t'(acc_rdata);

    always_comb
    begin
        acc_cur = fwd_reg ? fwd_row_reg : (acc_vld_rd_reg ? acc_rd : '0);
        for (int k = 0; k < CH_COUNT; k++)
        begin
            cal_add[k] = acc_cur.cal_sum[k] + CSW'(s1_samples_reg[k]);
            avg_add[k] = acc_cur.avg_sum[k] + ASW'(s1_samples_reg[k]);
        end
        cal_cnt1 = (CCW + 1)'(acc_cur.cal_cnt) + 1'b1;
        avg_cnt1 = (ACW + 1)'(acc_cur.avg_cnt) + 1'b1;
        cal_done = (cal_cnt1 == (CCW + 1)'(CAL_READS));
        avg_done = (avg_cnt1 == (ACW + 1)'(AVG_READS));

        acc_new = acc_cur;
        if (s1_op_reg == OP_CAL)
        begin
            s1_done = cal_done;
            if (cal_done)
            begin
                acc_new.cal_cnt = '0;
                acc_new.cal_sum = '0;
            end
            else
            begin
                acc_new.cal_cnt = cal_cnt1[CCW-1:0];
                acc_new.cal_sum = cal_add;
            end
        end
        else
        begin
            s1_done = avg_done;
            if (avg_done)
            begin
                acc_new.avg_cnt = '0;
                acc_new.avg_sum = '0;
            end
            else
            begin
                acc_new.avg_cnt = avg_cnt1[ACW-1:0];
                acc_new.avg_sum = avg_add;
            end
        end

        for (int k = 0; k < CH_COUNT; k++)
        begin
            div_src[k] = (s1_op_reg == OP_MEAS) ? DIV_W'(avg_add[k]) : DIV_W'(cal_add[k]);
        end
    end

    // a word popped behind a write to the same plate sees the ram's old row
    assign fwd_next = s1_valid_reg && pop_ok && (s1_plate_reg == in_plate);

    assign m_sel = (s2_op_reg == OP_MEAS) ? AVG_M : CAL_M;

    ppb_ram #(
        .WIDTH (BL_W),
        .DEPTH (PLATE_COUNT)
    ) u_bl_ram (
        .clk   (clk),
        .we    (bl_we),
        .waddr (ADDR_W'(s3_plate_reg)),
        .wdata (quot),
        .re    (s2_valid_reg),
        .raddr (ADDR_W'(s2_plate_reg)),
        .rdata (bl_rdata)
    );

    always_comb
    begin
        for (int k = 0; k < CH_COUNT; k++)
        begin
            if (s3_op_reg == OP_MEAS)
            begin
                quot[k] = SB'(s3_prod_reg[k] >> AVG_SH);
            end
            else
            begin
                quot[k] = SB'(s3_prod_reg[k] >> CAL_SH);
            end
        end
        base = bfwd_reg ? bfwd_data_reg : (bl_vld_rd_reg ? bl_rdata : '0);
        for (int k = 0; k < CH_COUNT; k++)
        begin
            corr[k] = {1'b0, quot[k]} - {1'b0, base[k]};
        end
    end

    assign bl_we     = s3_valid_reg && (s3_op_reg == OP_CAL) && s3_done_reg;
    assign bfwd_next = bl_we && s2_valid_reg && (s2_plate_reg == s3_plate_reg);

    always_comb
    begin
        p01 = $signed(s4_c_reg[0]) + $signed(s4_c_reg[1]);
        p13 = $signed(s4_c_reg[1]) + $signed(s4_c_reg[3]);
        p23 = $signed(s4_c_reg[2]) + $signed(s4_c_reg[3]);
        p02 = $signed(s4_c_reg[0]) + $signed(s4_c_reg[2]);
        m01 = half_tz(p01);
        m13 = half_tz(p13);
        m23 = half_tz(p23);
        m02 = half_tz(p02);
        dx  = m01 - m23;
        dy  = m13 - m02;
    end

    assign res_push  = s4_valid_reg;
    assign res_plate = s4_plate_reg;
    assign res_dx    = dx[DIFF_W-1:0];
    assign res_dy    = dy[DIFF_W-1:0];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            acc_vld_reg  <= '0;
            bl_vld_reg   <= '0;
            fwd_reg      <= 1'b0;
            bfwd_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pop_ok;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg && (s3_op_reg == OP_MEAS) && s3_done_reg;
            fwd_reg      <= fwd_next;
            bfwd_reg     <= bfwd_next;
            if (s1_valid_reg)
            begin
                acc_vld_reg[ADDR_W'(s1_plate_reg)] <= 1'b1;
            end
            if (bl_we)
            begin
                bl_vld_reg[ADDR_W'(s3_plate_reg)] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (pop_ok)
        begin
            s1_op_reg      <= in_op;
            s1_plate_reg   <= in_plate;
            s1_samples_reg <= in_samples;
            acc_vld_rd_reg <= acc_vld_reg[ADDR_W'(in_plate)];
        end
        fwd_row_reg <= acc_new;

        s2_op_reg    <= s1_op_reg;
        s2_done_reg  <= s1_done;
        s2_plate_reg <= s1_plate_reg;
        s2_src_reg   <= div_src;
        if (s2_valid_reg)
        begin
            bl_vld_rd_reg <= bl_vld_reg[ADDR_W'(s2_plate_reg)];
        end

        s3_op_reg    <= s2_op_reg;
        s3_done_reg  <= s2_done_reg;
        s3_plate_reg <= s2_plate_reg;
        for (int k = 0; k < CH_COUNT; k++)
        begin
            s3_prod_reg[k] <= PRW'(s2_src_reg[k]) * PRW'(m_sel);
        end
        bfwd_data_reg <= quot;

        s4_plate_reg <= s3_plate_reg;
        s4_c_reg     <= corr;
    end

endmodule
`default_nettype wire

// ===== rtl/core/ppb_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppb_outq: result queue
// holds finished balance words until popped, reports its fill level
// ----------------------------------------------------------------------------
module ppb_outq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [ppb_pkg::PLATE_W-1:0]   push_plate,
    input  logic [ppb_pkg::DIFF_W-1:0]    push_dx,
    input  logic [ppb_pkg::DIFF_W-1:0]    push_dy,
    input  logic                          pop,
    output logic                          empty,
    output logic [ppb_pkg::PLATE_W-1:0]   plate_out,
    output logic [ppb_pkg::DIFF_W-1:0]    diff_x,
    output logic [ppb_pkg::DIFF_W-1:0]    diff_y,
    output logic [ppb_pkg::OCNT_W-1:0]    count
);

    import ppb_pkg::*;

    typedef struct packed {
        logic [PLATE_W-1:0] plate;
        logic [DIFF_W-1:0]  dx;
        logic [DIFF_W-1:0]  dy;
    } oq_entry_t;

    oq_entry_t         entry_reg [OUT_DEPTH];
    logic [OQ_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_rd;

    assign empty     = (cnt_reg == '0);
    assign do_rd     = pop && !empty;
    assign count     = cnt_reg;
    assign plate_out = entry_reg[rd_ptr_reg].plate;
    assign diff_x    = entry_reg[rd_ptr_reg].dx;
    assign diff_y    = entry_reg[rd_ptr_reg].dy;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OQ_AW'(push);
        rd_ptr_next = rd_ptr_reg + OQ_AW'(do_rd);
        cnt_next    = cnt_reg + OCNT_W'(push) - OCNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{plate: push_plate, dx: push_dx, dy: push_dy};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pressure_plate_balance.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_plate_balance: four-sensor plate calibration and balance
// per-plate baseline averaging and averaged x/y balance of converter reads
// ----------------------------------------------------------------------------
// path: a measurement word that closes an average goes from its front queue
//   entry through s1 to s4, and s4 writes the result queue
// throughput: one word per cycle; the back end pops only while the result
//   queue can hold every word in its four stages
// reset: all sums, counts and baselines read as zero (per-plate valid bits),
//   queues empty; no clearing pass, words are taken right after reset
module pressure_plate_balance #(
    parameter int PLATE_COUNT = ppb_pkg::DEF_PLATE_COUNT,
    parameter int CAL_READS   = ppb_pkg::DEF_CAL_READS,
    parameter int AVG_READS   = ppb_pkg::DEF_AVG_READS,
    parameter int SAMPLE_BITS = ppb_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input word
    input  logic                               push,
    output logic                               full,
    input  logic                               op,
    input  logic [ppb_pkg::PLATE_W-1:0]        plate,
    input  logic [SAMPLE_BITS-1:0]             ch0,
    input  logic [SAMPLE_BITS-1:0]             ch1,
    input  logic [SAMPLE_BITS-1:0]             ch2,
    input  logic [SAMPLE_BITS-1:0]             ch3,
    // result word
    output logic                               empty,
    input  logic                               pop,
    output logic [ppb_pkg::PLATE_W-1:0]        plate_out,
    output logic signed [ppb_pkg::DIFF_W-1:0]  diff_x,
    output logic signed [ppb_pkg::DIFF_W-1:0]  diff_y
);

    import ppb_pkg::*;

    // front queue to back end
    logic                                  fq_valid;
    logic                                  fq_pop;
    logic                                  fq_op;
    logic [PLATE_W-1:0]                    fq_plate;
    logic [CH_COUNT-1:0][SAMPLE_BITS-1:0]  fq_samples;

    // back end to result queue
    logic                                  res_push;
    logic [PLATE_W-1:0]                    res_plate;
    logic [DIFF_W-1:0]                     res_dx;
    logic [DIFF_W-1:0]                     res_dy;
    logic [OCNT_W-1:0]                     outq_count;
    logic [DIFF_W-1:0]                     oq_dx;
    logic [DIFF_W-1:0]                     oq_dy;

    // front: take words, drop bad plate numbers, buffer a few
    ppb_front #(
        .PLATE_COUNT (PLATE_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .plate     (plate),
        .ch0       (ch0),
        .ch1       (ch1),
        .ch2       (ch2),
        .ch3       (ch3),
        .q_valid   (fq_valid),
        .q_pop     (fq_pop),
        .q_op      (fq_op),
        .q_plate   (fq_plate),
        .q_samples (fq_samples)
    );

    // back: accumulate, divide by read counts, baseline, balance
    ppb_back #(
        .PLATE_COUNT (PLATE_COUNT),
        .CAL_READS   (CAL_READS),
        .AVG_READS   (AVG_READS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (fq_valid),
        .in_pop     (fq_pop),
        .in_op      (fq_op),
        .in_plate   (fq_plate),
        .in_samples (fq_samples),
        .out_count  (outq_count),
        .res_push   (res_push),
        .res_plate  (res_plate),
        .res_dx     (res_dx),
        .res_dy     (res_dy)
    );

    // results wait here so a stalled consumer never stops the back end mid-word
    ppb_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_push),
        .push_plate (res_plate),
        .push_dx    (res_dx),
        .push_dy    (res_dy),
        .pop        (pop),
        .empty      (empty),
        .plate_out  (plate_out),
        .diff_x     (oq_dx),
        .diff_y     (oq_dy),
        .count      (outq_count)
    );

    assign diff_x = $signed(oq_dx);
    assign diff_y = $signed(oq_dy);

`ifndef SYNTHESIS
    // the pop credit check must leave a slot for every finished word
    a_outq_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (outq_count < OCNT_W'(OUT_DEPTH)))
        else $error("result queue written while full");

    // a word pushed with no pop must raise the fill level by one
    a_outq_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !(pop && !empty)) |=> (outq_count == $past(outq_count) + 1'b1))
        else $error("result queue fill level lost a word");

    // the back end never pops an empty front queue
    a_front_pop: assert property (@(posedge clk) disable iff (!rst_n)
        fq_pop |-> fq_valid)
        else $error("back end popped an empty front queue");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for pressure_plate_balance
// drives calibration and measurement words through the push/full side,
// predicts every balance word from a per-plate model of the sums and
// baselines, and checks each popped word in order against that prediction
// ----------------------------------------------------------------------------
module tb_top;
    import ppb_pkg::*;

    // block configuration, defaults of the package
    localparam int PLATES = DEF_PLATE_COUNT;
    localparam int CAL_N  = DEF_CAL_READS;
    localparam int AVG_N  = DEF_AVG_READS;
    localparam int SB     = DEF_SAMPLE_BITS;

    // settle time after every owed word has come out
    localparam int DRAIN_CYCLES = 20;
    // watchdog limit for the whole run
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SHOW_ERRORS  = 10;

    typedef struct {
        logic [PLATE_W-1:0]       plate;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } balance_t;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic                       op;
    logic [PLATE_W-1:0]         plate;
    logic [SB-1:0]              ch0;
    logic [SB-1:0]              ch1;
    logic [SB-1:0]              ch2;
    logic [SB-1:0]              ch3;
    logic                       empty;
    logic                       pop;
    logic [PLATE_W-1:0]         plate_out;
    logic signed [DIFF_W-1:0]   diff_x;
    logic signed [DIFF_W-1:0]   diff_y;

    // balance words still owed by the block, oldest first
    balance_t balance_due_q[$];

    // per-plate picture of the block's sums, counts and baselines
    int unsigned plate_baseline [PLATES][CH_COUNT];
    int unsigned cal_total      [PLATES][CH_COUNT];
    int unsigned cal_reads      [PLATES];
    int unsigned meas_total     [PLATES][CH_COUNT];
    int unsigned meas_reads     [PLATES];

    int  errors = 0;
    int  cycle_count = 0;
    // no random gaps on either side while set
    bit  calm;
    // long receiver hold-off requested by a test, in cycles
    int  rx_hold = 0;

    pressure_plate_balance dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .plate     (plate),
        .ch0       (ch0),
        .ch1       (ch1),
        .ch2       (ch2),
        .ch3       (ch3),
        .empty     (empty),
        .pop       (pop),
        .plate_out (plate_out),
        .diff_x    (diff_x),
        .diff_y    (diff_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor: fold one accepted word into the plate state, queue the
    // balance word when a measurement round closes
    // ------------------------------------------------------------------------
    function automatic void predict_balance(input logic op_v, input logic [PLATE_W-1:0] pl,
                                            input logic [SB-1:0] s0, input logic [SB-1:0] s1,
                                            input logic [SB-1:0] s2, input logic [SB-1:0] s3);
        int unsigned smp [CH_COUNT];
        int          corr [CH_COUNT];
        int          m01;
        int          m13;
        int          m23;
        int          m02;
        int          dx;
        int          dy;
        balance_t    due;
        smp[0] = s0;
        smp[1] = s1;
        smp[2] = s2;
        smp[3] = s3;
        // plates past the configured count are dropped untouched
        if (pl >= PLATES)
            return;
        if (op_v == OP_CAL)
        begin
            for (int k = 0; k < CH_COUNT; k++)
                cal_total[pl][k] += smp[k];
            cal_reads[pl]++;
            // full calibration round: new baseline, sums start over
            if (cal_reads[pl] >= CAL_N)
            begin
                for (int k = 0; k < CH_COUNT; k++)
                begin
                    plate_baseline[pl][k] = cal_total[pl][k] / CAL_N;
                    cal_total[pl][k] = 0;
                end
                cal_reads[pl] = 0;
            end
            return;
        end
        for (int k = 0; k < CH_COUNT; k++)
            meas_total[pl][k] += smp[k];
        meas_reads[pl]++;
        if (meas_reads[pl] < AVG_N)
            return;
        for (int k = 0; k < CH_COUNT; k++)
        begin
            corr[k] = int'(meas_total[pl][k] / AVG_N) - int'(plate_baseline[pl][k]);
            meas_total[pl][k] = 0;
        end
        meas_reads[pl] = 0;
        // integer divide truncates toward zero, as the block's halving does
        m01 = (corr[0] + corr[1]) / 2;
        m13 = (corr[1] + corr[3]) / 2;
        m23 = (corr[2] + corr[3]) / 2;
        m02 = (corr[0] + corr[2]) / 2;
        dx  = m01 - m23;
        dy  = m13 - m02;
        due.plate = pl;
        due.dx    = dx[DIFF_W-1:0];
        due.dy    = dy[DIFF_W-1:0];
        balance_due_q.push_back(due);
    endfunction

    function automatic void log_error(input string msg);
        if (errors < SHOW_ERRORS)
            $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
        errors++;
    endfunction

    // every accepted input word goes through the predictor
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            predict_balance(op, plate, ch0, ch1, ch2, ch3);
    end

    // every popped balance word is checked against the oldest prediction
    always @(posedge clk)
    begin : check_balance
        balance_t due;
        if (rst_n && pop && !empty)
        begin
            if (balance_due_q.size() == 0)
            begin
                log_error($sformatf("unexpected word plate %0d dx %0d dy %0d",
                                    plate_out, diff_x, diff_y));
            end
            else
            begin
                due = balance_due_q.pop_front();
                if (plate_out !== due.plate || diff_x !== due.dx || diff_y !== due.dy)
                    log_error($sformatf({"expected plate %0d dx %0d dy %0d, ",
                                         "got plate %0d dx %0d dy %0d"},
                                        due.plate, due.dx, due.dy, plate_out, diff_x, diff_y));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random gap before each pop, long hold-off once when asked for
    // ------------------------------------------------------------------------
    initial
    begin : drain_results
        int gap;
        bit hold_taken;
        hold_taken = 1'b0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0 && !hold_taken)
            begin
                gap = rx_hold;
                hold_taken = 1'b1;
            end
            else
            begin
                gap = calm ? 0 : $urandom_range(0, 6);
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // sender: one word per call, push stays high into the next call when
    // there is no gap, so it is never lowered and raised in one step
    // ------------------------------------------------------------------------
    task automatic send_word(input logic op_v, input logic [PLATE_W-1:0] pl,
                             input logic [SB-1:0] s0, input logic [SB-1:0] s1,
                             input logic [SB-1:0] s2, input logic [SB-1:0] s3);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        op    <= op_v;
        plate <= pl;
        ch0   <= s0;
        ch1   <= s1;
        ch2   <= s2;
        ch3   <= s3;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // lower push, let every owed word come out, then a few more cycles
    task automatic wait_quiet();
        push <= 1'b0;
        while (balance_due_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly full-range random, with the rails showing up often
    function automatic logic [SB-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return SB'($urandom_range(0, (1 << SB) - 1));
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // measurement before any calibration: baseline still zero after reset;
    // the odd ch2 read must vanish in the truncating average
    task automatic test_uncalibrated();
        for (int k = 0; k < AVG_N - 1; k++)
            send_word(OP_MEAS, 3'd1, '1, '1, '0, '0);
        send_word(OP_MEAS, 3'd1, '1, '1, SB'(3), '0);
    endtask

    // calibrate plate 0 to the opposite rails, with measurement reads of the
    // same plate mixed in, so the closing read sees the new baseline and
    // drives diff_x to its largest reachable value
    task automatic test_calibrated_extremes();
        for (int k = 0; k < CAL_N; k++)
        begin
            send_word(OP_CAL, 3'd0, '0, '0, '1, '1);
            if (k % 5 == 2)
                send_word(OP_MEAS, 3'd0, '1, '1, '0, '0);
        end
        send_word(OP_MEAS, 3'd0, '1, '1, '0, '0);
    endtask

    // mostly whole rounds on random plates, plus loose single words that
    // knock the round counts out of step; calm stretches now and then
    task automatic test_random_rounds();
        int sent;
        int kind;
        logic [PLATE_W-1:0] pl;
        sent = 0;
        while (sent < 560)
        begin
            calm = ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 9);
            pl   = PLATE_W'($urandom_range(0, PLATES - 1));
            if (kind <= 5)
            begin
                for (int k = 0; k < AVG_N; k++)
                    send_word(OP_MEAS, pl, pick_sample(), pick_sample(),
                              pick_sample(), pick_sample());
                sent += AVG_N;
            end
            else if (kind <= 7)
            begin
                for (int k = 0; k < CAL_N; k++)
                    send_word(OP_CAL, pl, pick_sample(), pick_sample(),
                              pick_sample(), pick_sample());
                sent += CAL_N;
            end
            else
            begin
                send_word(($urandom_range(0, 1) == 1) ? OP_MEAS : OP_CAL,
                          PLATE_W'($urandom_range(0, (1 << PLATE_W) - 1)),
                          pick_sample(), pick_sample(), pick_sample(), pick_sample());
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    // receiver holds off for a long stretch while the sender streams
    // closing rounds at full rate: result queue fills, then full rises
    task automatic test_output_stall();
        rx_hold = 300;
        calm = 1'b1;
        for (int k = 0; k < 64; k++)
            send_word(OP_MEAS, 3'd3, pick_sample(), pick_sample(),
                      pick_sample(), pick_sample());
        calm = 1'b0;
    endtask

    initial
    begin
        calm = 1'b0;
        for (int p = 0; p < PLATES; p++)
        begin
            for (int k = 0; k < CH_COUNT; k++)
            begin
                plate_baseline[p][k] = 0;
                cal_total[p][k]      = 0;
                meas_total[p][k]     = 0;
            end
            cal_reads[p]  = 0;
            meas_reads[p] = 0;
        end
        rst_n <= 1'b0;
        push  <= 1'b0;
        op    <= OP_CAL;
        plate <= '0;
        ch0   <= '0;
        ch1   <= '0;
        ch2   <= '0;
        ch3   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_uncalibrated();
        wait_quiet();
        test_calibrated_extremes();
        wait_quiet();
        test_random_rounds();
        wait_quiet();
        test_output_stall();
        wait_quiet();

        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
